FILE: src/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types, constants and codes of the triangle rasterizer with depth test.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int DEPTH_BITS = 16;

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int AW = XB + YB;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;

  // edge function, doubled area and offset widths
  localparam int SW = 28;
  localparam int OW = 14;
  // depth multiplier product and weighted sum widths
  localparam int PW = 45;
  localparam int NW = 48;

  localparam int CNT_W      = 5;
  localparam int SETUP_LAST = 8;
  localparam int DMUL_LAST  = 3;
  localparam int CFG_AW     = 4;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FAR    = 2'd2
  } reg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic [15:0]        az;
    logic signed [11:0] bx;
    logic signed [11:0] by;
    logic [15:0]        bz;
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic [15:0]        cz;
    logic [23:0]        color;
    logic [13:0]        read_index;
  } in_t;

  typedef struct packed {
    logic [14:0] pixels_written;
    logic        drawn;
    logic [23:0] pixel_color;
    logic [15:0] pixel_depth;
  } out_t;

  typedef struct packed {
    logic [7:0]  width;
    logic [7:0]  height;
    logic [15:0] far;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_BOX, ST_SETUP, ST_AREA, ST_PIX, ST_DMUL, ST_DABS,
    ST_DSAT, ST_DIV, ST_DWR, ST_FILL, ST_DCLR, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_BOX, OP_SETUP, OP_MARK, OP_PIX, OP_DMUL, OP_DABS,
    OP_DSAT, OP_DIV, OP_DWR, OP_SWEEP, OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    SW_RST, SW_FILL, SW_CLR
  } sweep_t;

  typedef struct packed {
    dp_op_t           op;
    sweep_t           sw;
    logic [CNT_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       skip;
    logic       empty;
    logic       area_zero;
    logic       covered;
    logic       last;
    logic       need_div;
  } sts_t;

endpackage

FILE: src/trd_cfg.sv
// ----------------------------------------------------------------------------
// trd_cfg
// Configuration registers behind the register port: active size, far depth.
// ----------------------------------------------------------------------------
module trd_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [trd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output trd_pkg::cfg_t             cfg
);
  import trd_pkg::*;

  logic [7:0]  width_r, width_nxt;
  logic [7:0]  height_r, height_nxt;
  logic [15:0] far_r, far_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    far_nxt    = far_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_nxt  = pwdata[7:0];
        REG_HEIGHT: height_nxt = pwdata[7:0];
        REG_FAR:    far_nxt    = pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {24'd0, width_r};
      REG_HEIGHT: prdata = {24'd0, height_r};
      REG_FAR:    prdata = {16'd0, far_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 8'd128;
      far_r    <= 16'hffff;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      far_r    <= far_nxt;
    end
  end

  assign cfg = '{width: width_r, height: height_r, far: far_r};

endmodule

FILE: src/trd_ctrl.sv
// ----------------------------------------------------------------------------
// trd_ctrl
// Sequencer: issues datapath commands per item kind and owns both handshakes.
// ----------------------------------------------------------------------------
module trd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  trd_pkg::sts_t  sts,
  output trd_pkg::cmd_t  cmd
);
  import trd_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             fin_go;

  assign fin_go = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:   if (sts.last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_BOX;
      ST_BOX: begin
        unique case (sts.kind)
          KIND_DRAW:  state_nxt = sts.skip ? ST_FIN : ST_SETUP;
          KIND_FILL:  state_nxt = ST_FILL;
          KIND_CLEAR: state_nxt = ST_DCLR;
          default:    state_nxt = ST_FIN;
        endcase
      end
      ST_SETUP: if (cnt_r == CNT_W'(SETUP_LAST)) state_nxt = ST_AREA;
      ST_AREA:  state_nxt = (sts.area_zero || sts.empty) ? ST_FIN : ST_PIX;
      ST_PIX: begin
        if (sts.covered) state_nxt = ST_DMUL;
        else if (sts.last) state_nxt = ST_FIN;
      end
      ST_DMUL:  if (cnt_r == CNT_W'(DMUL_LAST)) state_nxt = ST_DABS;
      ST_DABS:  state_nxt = ST_DSAT;
      ST_DSAT:  state_nxt = sts.need_div ? ST_DIV : ST_DWR;
      ST_DIV:   if (cnt_r == CNT_W'(DEPTH_BITS - 1)) state_nxt = ST_DWR;
      ST_DWR:   state_nxt = sts.last ? ST_FIN : ST_PIX;
      ST_FILL:  if (sts.empty || sts.last) state_nxt = ST_FIN;
      ST_DCLR:  if (sts.last) state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
  end

  always_comb begin
    cmd      = '{op: OP_IDLE, sw: SW_RST, step: cnt_r};
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLR:   cmd.op = OP_SWEEP;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_BOX:   cmd.op = OP_BOX;
      ST_SETUP: cmd.op = OP_SETUP;
      ST_AREA:  if (!sts.area_zero) cmd.op = OP_MARK;
      ST_PIX:   cmd.op = OP_PIX;
      ST_DMUL:  cmd.op = OP_DMUL;
      ST_DABS:  cmd.op = OP_DABS;
      ST_DSAT:  cmd.op = OP_DSAT;
      ST_DIV:   cmd.op = OP_DIV;
      ST_DWR:   cmd.op = OP_DWR;
      ST_FILL: begin
        if (!sts.empty) begin
          cmd.op = OP_SWEEP;
          cmd.sw = SW_FILL;
        end
      end
      ST_DCLR: begin
        cmd.op = OP_SWEEP;
        cmd.sw = SW_CLR;
      end
      ST_FIN:   if (fin_go) cmd.op = OP_OUT;
      default:  ;
    endcase
  end

  assign out_valid_nxt = (cmd.op == OP_OUT) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_to_box: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_BOX))
    else $error("accepted item did not start");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == CNT_W'(DEPTH_BITS - 1)) |=> (state_r == ST_DWR))
    else $error("divider ran past its last step");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=> (state_r == ST_FIN && out_valid_r))
    else $error("result overwritten while pending");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result raised outside finish");

endmodule

FILE: src/trd_dp.sv
// ----------------------------------------------------------------------------
// trd_dp
// Datapath: box clip, edge setup, pixel walk, depth interpolation, stores.
// ----------------------------------------------------------------------------
module trd_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  trd_pkg::cmd_t  cmd,
  input  trd_pkg::cfg_t  cfg,
  input  trd_pkg::in_t   in_data,
  output trd_pkg::sts_t  sts,
  output trd_pkg::out_t  out_data
);
  import trd_pkg::*;

  in_t  item_r;
  out_t out_r;

  logic [7:0]         ew, eh;
  logic signed [12:0] wm1, hm1;
  logic signed [12:0] mnx, mxx, mny, mxy;
  logic signed [12:0] mnx_c, mxx_c, mny_c, mxy_c;
  logic               skip, empty_draw;
  logic [XB-1:0]      xlo_n, xhi_n;
  logic [YB-1:0]      ylo_n, yhi_n;
  logic               empty_n;

  logic signed [12:0] dx12_r, dx23_r, dx31_r, dy12_r, dy23_r, dy31_r;
  logic [XB-1:0]      x_r, xlo_r, xhi_r;
  logic [YB-1:0]      y_r, ylo_r, yhi_r;
  logic               empty_r;
  logic               x_end, last;

  logic signed [OW-1:0] x0, y0;
  logic signed [OW-1:0] ox1, oy1, ox2, oy2, ox3, oy3;
  logic signed [16:0]   mul_a;
  logic signed [SW-1:0] mul_b;
  logic signed [PW-1:0] mul_p, prod_r;
  logic signed [SW-1:0] p_s;
  logic signed [NW-1:0] p_n;

  logic signed [SW-1:0] s1_r, s2_r, s3_r, r1_r, r2_r, r3_r, area_r;
  logic signed [SW-1:0] area_neg;
  logic [SW-1:0]        amag_r;
  logic                 aneg_r;
  logic signed [NW-1:0] num_r, num_neg;
  logic [NW-2:0]        mag_r;
  logic                 nneg_r, nzero_r;
  logic                 sat, depth_zero, covered;
  logic [SW-1:0]        rem_r;
  logic [SW:0]          div_t;
  logic                 div_ge;
  logic [DEPTH_BITS-1:0] lo_r;

  logic [14:0]          count_r;
  logic                 drawn_r;
  logic                 adv, upd_edges;

  logic [23:0]           color_mem [STORE_SIZE];
  logic [DEPTH_BITS-1:0] depth_mem [STORE_SIZE];
  logic [23:0]           color_rd_r;
  logic [DEPTH_BITS-1:0] depth_rd_r;
  logic [AW-1:0]         waddr, raddr;
  logic                  cwe, dwe, pass;
  logic [23:0]           cwd;
  logic [DEPTH_BITS-1:0] dwd;

  function automatic logic signed [11:0] min3(input logic signed [11:0] a,
                                               input logic signed [11:0] b,
                                               input logic signed [11:0] c);
    logic signed [11:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [11:0] max3(input logic signed [11:0] a,
                                               input logic signed [11:0] b,
                                               input logic signed [11:0] c);
    logic signed [11:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // bounding box clip against the active size
  always_comb begin
    ew    = (cfg.width > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : cfg.width;
    eh    = (cfg.height > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : cfg.height;
    wm1   = $signed({5'd0, ew}) - 13'sd1;
    hm1   = $signed({5'd0, eh}) - 13'sd1;
    mnx   = 13'(min3(item_r.ax, item_r.bx, item_r.cx));
    mxx   = 13'(max3(item_r.ax, item_r.bx, item_r.cx));
    mny   = 13'(min3(item_r.ay, item_r.by, item_r.cy));
    mxy   = 13'(max3(item_r.ay, item_r.by, item_r.cy));
    mnx_c = (mnx < 13'sd0) ? 13'sd0 : mnx;
    mny_c = (mny < 13'sd0) ? 13'sd0 : mny;
    mxx_c = (mxx > wm1) ? wm1 : mxx;
    mxy_c = (mxy > hm1) ? hm1 : mxy;
    skip       = (mnx_c > mxx_c + 13'sd1) || (mny_c > mxy_c + 13'sd1);
    empty_draw = (mnx_c > mxx_c) || (mny_c > mxy_c);
    case (item_r.kind)
      KIND_DRAW: begin
        xlo_n   = mnx_c[XB-1:0];
        xhi_n   = mxx_c[XB-1:0];
        ylo_n   = mny_c[YB-1:0];
        yhi_n   = mxy_c[YB-1:0];
        empty_n = empty_draw;
      end
      KIND_FILL: begin
        xlo_n   = '0;
        xhi_n   = XB'(ew - 8'd1);
        ylo_n   = '0;
        yhi_n   = YB'(eh - 8'd1);
        empty_n = (ew == 8'd0) || (eh == 8'd0);
      end
      default: begin
        xlo_n   = '0;
        xhi_n   = XB'(MAX_WIDTH - 1);
        ylo_n   = '0;
        yhi_n   = YB'(MAX_HEIGHT - 1);
        empty_n = 1'b0;
      end
    endcase
  end

  // walk position
  assign x_end = (x_r == xhi_r);
  assign last  = x_end && (y_r == yhi_r);
  assign covered = ((s1_r > 0) && (s2_r > 0) && (s3_r > 0)) ||
                   ((s1_r <= 0) && (s2_r <= 0) && (s3_r <= 0));
  assign adv = (cmd.op == OP_PIX && !covered) || cmd.op == OP_DWR || cmd.op == OP_SWEEP;
  assign upd_edges = adv && (cmd.op != OP_SWEEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      y_r   <= '0;
      xlo_r <= '0;
      ylo_r <= '0;
      xhi_r <= XB'(MAX_WIDTH - 1);
      yhi_r <= YB'(MAX_HEIGHT - 1);
    end else if (cmd.op == OP_BOX) begin
      xlo_r <= xlo_n;
      xhi_r <= xhi_n;
      ylo_r <= ylo_n;
      yhi_r <= yhi_n;
      x_r   <= xlo_n;
      y_r   <= ylo_n;
    end else if (adv) begin
      if (x_end) begin
        x_r <= xlo_r;
        if (y_r != yhi_r) y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) item_r <= in_data;
    if (cmd.op == OP_BOX) begin
      empty_r <= empty_n;
      dx12_r  <= 13'(item_r.ax) - 13'(item_r.bx);
      dx23_r  <= 13'(item_r.bx) - 13'(item_r.cx);
      dx31_r  <= 13'(item_r.cx) - 13'(item_r.ax);
      dy12_r  <= 13'(item_r.ay) - 13'(item_r.by);
      dy23_r  <= 13'(item_r.by) - 13'(item_r.cy);
      dy31_r  <= 13'(item_r.cy) - 13'(item_r.ay);
    end
  end

  // shared multiplier, registered product
  always_comb begin
    x0  = $signed({{(OW-XB){1'b0}}, xlo_r});
    y0  = $signed({{(OW-YB){1'b0}}, ylo_r});
    ox1 = x0 - OW'(item_r.bx);
    oy1 = y0 - OW'(item_r.by);
    ox2 = x0 - OW'(item_r.cx);
    oy2 = y0 - OW'(item_r.cy);
    ox3 = x0 - OW'(item_r.ax);
    oy3 = y0 - OW'(item_r.ay);
    mul_a = '0;
    mul_b = '0;
    if (cmd.op == OP_DMUL) begin
      case (cmd.step)
        CNT_W'(0): begin mul_a = $signed({1'b0, item_r.az}); mul_b = s2_r; end
        CNT_W'(1): begin mul_a = $signed({1'b0, item_r.bz}); mul_b = s3_r; end
        default:   begin mul_a = $signed({1'b0, item_r.cz}); mul_b = s1_r; end
      endcase
    end else begin
      case (cmd.step)
        CNT_W'(0): begin mul_a = 17'(dy12_r); mul_b = SW'(ox1); end
        CNT_W'(1): begin mul_a = 17'(dx12_r); mul_b = SW'(oy1); end
        CNT_W'(2): begin mul_a = 17'(dy23_r); mul_b = SW'(ox2); end
        CNT_W'(3): begin mul_a = 17'(dx23_r); mul_b = SW'(oy2); end
        CNT_W'(4): begin mul_a = 17'(dy31_r); mul_b = SW'(ox3); end
        CNT_W'(5): begin mul_a = 17'(dx31_r); mul_b = SW'(oy3); end
        CNT_W'(6): begin mul_a = 17'(dy31_r); mul_b = SW'(dx23_r); end
        CNT_W'(7): begin mul_a = 17'(dx31_r); mul_b = SW'(dy23_r); end
        default:   ;
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;
  assign p_s   = prod_r[SW-1:0];
  assign p_n   = $signed({{(NW-PW){prod_r[PW-1]}}, prod_r});

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  // edge setup and incremental stepping
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SETUP) begin
      case (cmd.step)
        CNT_W'(1): begin s1_r <= p_s; r1_r <= p_s; end
        CNT_W'(2): begin s1_r <= s1_r - p_s; r1_r <= s1_r - p_s; end
        CNT_W'(3): begin s2_r <= p_s; r2_r <= p_s; end
        CNT_W'(4): begin s2_r <= s2_r - p_s; r2_r <= s2_r - p_s; end
        CNT_W'(5): begin s3_r <= p_s; r3_r <= p_s; end
        CNT_W'(6): begin s3_r <= s3_r - p_s; r3_r <= s3_r - p_s; end
        CNT_W'(7): area_r <= p_s;
        CNT_W'(8): area_r <= area_r - p_s;
        default:   ;
      endcase
    end else if (upd_edges) begin
      if (x_end) begin
        r1_r <= r1_r - SW'(dx12_r);
        r2_r <= r2_r - SW'(dx23_r);
        r3_r <= r3_r - SW'(dx31_r);
        s1_r <= r1_r - SW'(dx12_r);
        s2_r <= r2_r - SW'(dx23_r);
        s3_r <= r3_r - SW'(dx31_r);
      end else begin
        s1_r <= s1_r + SW'(dy12_r);
        s2_r <= s2_r + SW'(dy23_r);
        s3_r <= s3_r + SW'(dy31_r);
      end
    end
  end

  // depth: weighted sum, sign and saturation, restoring divide
  assign area_neg   = -area_r;
  assign num_neg    = -num_r;
  assign sat        = mag_r >= {{(NW-1-SW-DEPTH_BITS){1'b0}}, amag_r, {DEPTH_BITS{1'b0}}};
  assign depth_zero = nzero_r || (nneg_r ^ aneg_r);
  assign div_t      = {rem_r, lo_r[DEPTH_BITS-1]};
  assign div_ge     = div_t >= {1'b0, amag_r};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_MARK) begin
      aneg_r <= area_r[SW-1];
      amag_r <= area_r[SW-1] ? area_neg : area_r;
    end
    if (cmd.op == OP_DMUL) begin
      case (cmd.step) inside
        CNT_W'(1):            num_r <= p_n;
        CNT_W'(2), CNT_W'(3): num_r <= num_r + p_n;
        default:              ;
      endcase
    end
    if (cmd.op == OP_DABS) begin
      nneg_r  <= num_r[NW-1];
      nzero_r <= (num_r == '0);
      mag_r   <= num_r[NW-1] ? num_neg[NW-2:0] : num_r[NW-2:0];
    end
    if (cmd.op == OP_DSAT) begin
      rem_r <= mag_r[SW+DEPTH_BITS-1:DEPTH_BITS];
      if (depth_zero) lo_r <= '0;
      else if (sat) lo_r <= '1;
      else lo_r <= mag_r[DEPTH_BITS-1:0];
    end
    if (cmd.op == OP_DIV) begin
      rem_r <= div_ge ? SW'(div_t - {1'b0, amag_r}) : div_t[SW-1:0];
      lo_r  <= {lo_r[DEPTH_BITS-2:0], div_ge};
    end
  end

  // stores
  assign waddr = {y_r, x_r};
  assign raddr = (item_r.kind == KIND_READ) ? AW'(item_r.read_index) : waddr;
  assign pass  = lo_r < depth_rd_r;

  always_comb begin
    cwe = 1'b0;
    dwe = 1'b0;
    cwd = item_r.color;
    dwd = lo_r;
    if (cmd.op == OP_SWEEP) begin
      case (cmd.sw)
        SW_RST: begin
          cwe = 1'b1;
          dwe = 1'b1;
          cwd = '0;
          dwd = '1;
        end
        SW_FILL: cwe = 1'b1;
        default: begin
          dwe = 1'b1;
          dwd = cfg.far[DEPTH_BITS-1:0];
        end
      endcase
    end else if (cmd.op == OP_DWR && pass) begin
      cwe = 1'b1;
      dwe = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cwe) color_mem[waddr] <= cwd;
    if (dwe) depth_mem[waddr] <= dwd;
    color_rd_r <= color_mem[raddr];
    depth_rd_r <= depth_mem[raddr];
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      count_r <= '0;
      drawn_r <= 1'b0;
    end else begin
      if (cmd.op == OP_MARK) drawn_r <= 1'b1;
      if ((cmd.op == OP_SWEEP && cmd.sw == SW_FILL) || (cmd.op == OP_DWR && pass)) begin
        count_r <= count_r + 1'b1;
      end
    end
    if (cmd.op == OP_OUT) begin
      out_r.pixels_written <= count_r;
      out_r.drawn          <= drawn_r;
      out_r.pixel_color    <= (item_r.kind == KIND_READ) ? color_rd_r : '0;
      out_r.pixel_depth    <= (item_r.kind == KIND_READ) ? 16'(depth_rd_r) : '0;
    end
  end

  assign out_data = out_r;

  assign sts = '{kind: item_r.kind, skip: skip, empty: empty_r,
                 area_zero: (area_r == '0), covered: covered, last: last,
                 need_div: !depth_zero && !sat};

endmodule

FILE: src/triangle_raster_depth_test.sv
// ----------------------------------------------------------------------------
// triangle_raster_depth_test
// Triangle rasterizer with depth test over internal 128x128 color/depth stores.
// ----------------------------------------------------------------------------
// draw: box clip and edge setup, then a walk over the box pixels; a covered pixel
//   takes depth multiply, sign, saturate, divide and write (no divide when the
//   depth is zero or saturates); fill sweeps width*height, clear all, read one entry
// one item in flight; the result register lets the next item enter early
// after reset a clearing pass over all 16384 entries sets colors to 0 and depths to
//   all ones, one entry a cycle, with in_ready low; config writes still taken
module triangle_raster_depth_test (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  trd_pkg::in_t               in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output trd_pkg::out_t              out_data,
  // register port, setup beat then access beat per write
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [trd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import trd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // active size and far depth
  trd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer and handshakes
  trd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, walk and stores
  trd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
